// File: hdl/audio_register_snoop_shadow_fifo_macros.svh
// assertion macros shared by the audio register snoop modules
`ifndef AUDIO_REGISTER_SNOOP_SHADOW_FIFO_MACROS_SVH
`define AUDIO_REGISTER_SNOOP_SHADOW_FIFO_MACROS_SVH

// same-cycle implication, disabled during reset
`define ARSSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ARSSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/arssf_pkg.sv
// types and constants shared by the audio register snoop modules
`default_nettype none

package arssf_pkg;

    // input transaction
    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] bus_address;
        logic [15:0] write_value;
        logic [2:0]  access_width;
        logic [63:0] time_stamp;
    } arssf_in_t;

    // result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] event_address;
        logic [15:0] event_value;
        logic [2:0]  event_width;
        logic [63:0] event_time;
        logic [8:0]  pending;
        logic [31:0] dropped;
        logic [31:0] captured;
        logic [4:0]  slot_index;
        logic [15:0] slot_value;
        logic        slot_seen;
        logic        last;
    } arssf_out_t;

    // one stored bus write in the event queue
    typedef struct packed {
        logic [23:0] address;
        logic [15:0] value;
        logic [2:0]  width;
        logic [63:0] ticks;
    } arssf_entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       emit;
        logic [4:0] slot;
    } arssf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic snap_go;
    } arssf_stat_t;

    // function codes
    localparam logic [1:0] FN_CAPTURE  = 2'd0;
    localparam logic [1:0] FN_PEEK     = 2'd1;
    localparam logic [1:0] FN_POP      = 2'd2;
    localparam logic [1:0] FN_SNAPSHOT = 2'd3;

    // result status codes
    localparam logic [2:0] STS_QUEUED  = 3'd0;
    localparam logic [2:0] STS_DROPPED = 3'd1;
    localparam logic [2:0] STS_IGNORED = 3'd2;
    localparam logic [2:0] STS_EMPTY   = 3'd3;
    localparam logic [2:0] STS_EVENT   = 3'd4;
    localparam logic [2:0] STS_SLOT    = 3'd5;
    localparam logic [2:0] STS_POPPED  = 3'd6;

    // custom chip page and audio register offsets
    localparam logic [11:0] AUDIO_PAGE     = 12'hdff;
    localparam logic [11:0] REG_DMACON     = 12'h096;
    localparam logic [11:0] REG_DMACON_HI  = 12'h097;
    localparam logic [11:0] REG_INTENA     = 12'h09a;
    localparam logic [11:0] REG_INTREQ     = 12'h09c;
    localparam logic [11:0] REG_ADKCON     = 12'h09e;
    localparam logic [11:0] REG_ADKCON_HI  = 12'h09f;
    localparam logic [11:0] CHAN_FIRST     = 12'h0a0;
    localparam logic [11:0] CHAN_LAST_WORD = 12'h0da;
    localparam logic [11:0] CHAN_LAST_BYTE = 12'h0db;
    localparam logic [3:0]  CHAN_REG_LAST  = 4'd10;

    // byte access width
    localparam logic [2:0] WIDTH_BYTE = 3'd1;

    // shadow layout
    localparam int          GLOBAL_COUNT   = 4;
    localparam int          CHAN_SLOTS     = 24;
    localparam logic [4:0]  REGS_PER_CHAN  = 5'd6;
    localparam logic [4:0]  SLOT_FIRST_CH  = 5'd4;
    localparam logic [4:0]  SLOT_LAST      = 5'd27;

endpackage

`default_nettype wire

// File: hdl/arssf_datapath.sv
// datapath: shadow registers, event queue memory, counters and result register
`default_nettype none
`include "audio_register_snoop_shadow_fifo_macros.svh"

module arssf_datapath
    import arssf_pkg::*;
#(
    parameter int EVENT_DEPTH = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire arssf_in_t   item,
    input  wire arssf_cmd_t  cmd,
    output arssf_stat_t      stat,
    output arssf_out_t       result,
    output logic             result_valid
);

    localparam int PTR_W = $clog2(EVENT_DEPTH);
    localparam int CNT_W = $clog2(EVENT_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(EVENT_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(EVENT_DEPTH);

    // event queue memory
    arssf_entry_t mem [EVENT_DEPTH];
    arssf_entry_t head_reg;

    // control and shadow state
    logic                enable_reg,  enable_next;
    logic [PTR_W-1:0]    rd_ptr_reg,  rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg,  wr_ptr_next;
    logic [CNT_W-1:0]    fill_reg,    fill_next;
    logic [CNT_W-1:0]    skipped_reg, skipped_next;
    logic [14:0]         global_reg  [GLOBAL_COUNT];
    logic [14:0]         global_next [GLOBAL_COUNT];
    logic [GLOBAL_COUNT-1:0] gseen_reg, gseen_next;
    logic [15:0]         chan_reg    [CHAN_SLOTS];
    logic [15:0]         chan_next   [CHAN_SLOTS];
    logic [CHAN_SLOTS-1:0] cseen_reg, cseen_next;
    logic [63:0]         latest_reg,  latest_next;
    logic [31:0]         queued_reg,  queued_next;
    logic [31:0]         drop_reg,    drop_next;
    arssf_in_t           item_reg;
    arssf_out_t          result_reg,  result_next;
    logic                result_valid_reg;

    // decode of the latched write
    logic [11:0]  offset;
    logic [11:0]  word_off;
    logic [11:0]  chan_off;
    logic         page_hit;
    logic         range_hit;
    logic         hit;
    logic [15:0]  word;
    logic         g_hit;
    logic [1:0]   g_idx;
    logic         c_hit;
    logic [4:0]   c_idx;
    logic         full;
    logic         mem_we;
    arssf_entry_t wr_entry;

    // snapshot slot selection
    logic [4:0]   slot_ci;
    logic [15:0]  slot_value;
    logic         slot_seen;
    logic [CNT_W+8:0] fill_ext;
    logic [CNT_W+8:0] skip_ext;

    // address decode and byte lane replication
    always_comb
    begin
        offset    = item_reg.bus_address[11:0];
        word_off  = {offset[11:1], 1'b0};
        page_hit  = (item_reg.bus_address[23:12] == AUDIO_PAGE);
        range_hit = (offset inside {[CHAN_FIRST:CHAN_LAST_BYTE],
                                    [REG_DMACON:REG_DMACON_HI],
                                    [REG_INTENA:REG_ADKCON_HI]});
        hit       = enable_reg && page_hit && range_hit;
        word      = (item_reg.access_width == WIDTH_BYTE) ?
                    {item_reg.write_value[7:0], item_reg.write_value[7:0]} :
                    item_reg.write_value;
        g_hit = 1'b1;
        g_idx = 2'd0;
        case (word_off)
            REG_DMACON: g_idx = 2'd0;
            REG_INTENA: g_idx = 2'd1;
            REG_INTREQ: g_idx = 2'd2;
            REG_ADKCON: g_idx = 2'd3;
            default:    g_hit = 1'b0;
        endcase
        chan_off = word_off - CHAN_FIRST;
        c_hit = (word_off inside {[CHAN_FIRST:CHAN_LAST_WORD]}) &&
                (chan_off[3:0] <= CHAN_REG_LAST);
        c_idx = 5'(chan_off[5:4]) * REGS_PER_CHAN + 5'(chan_off[3:1]);
        full  = (fill_reg == FILL_FULL);
    end

    // shadow entry selected for the snapshot slot
    always_comb
    begin
        slot_ci    = cmd.slot - SLOT_FIRST_CH;
        slot_value = 16'd0;
        slot_seen  = 1'b0;
        if (cmd.slot < SLOT_FIRST_CH)
        begin
            slot_value = {1'b0, global_reg[cmd.slot[1:0]]};
            slot_seen  = gseen_reg[cmd.slot[1:0]];
        end
        else if (slot_ci < 5'(CHAN_SLOTS))
        begin
            slot_value = chan_reg[slot_ci];
            slot_seen  = cseen_reg[slot_ci];
        end
    end

    // next state and result of the transaction in progress
    always_comb
    begin
        enable_next  = enable_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        fill_next    = fill_reg;
        skipped_next = skipped_reg;
        global_next  = global_reg;
        gseen_next   = gseen_reg;
        chan_next    = chan_reg;
        cseen_next   = cseen_reg;
        latest_next  = latest_reg;
        queued_next  = queued_reg;
        drop_next    = drop_reg;
        mem_we       = 1'b0;
        result_next  = '0;
        result_next.status = STS_IGNORED;
        result_next.last   = 1'b1;

        if (cfg_we)
        begin
            enable_next = cfg_wdata;
            // enabling starts from a clean shadow and an empty queue
            if (cfg_wdata)
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                fill_next   = '0;
                for (int i = 0; i < GLOBAL_COUNT; i++)
                begin
                    global_next[i] = '0;
                end
                gseen_next = '0;
                for (int i = 0; i < CHAN_SLOTS; i++)
                begin
                    chan_next[i] = '0;
                end
                cseen_next  = '0;
                latest_next = '0;
                queued_next = '0;
                drop_next   = '0;
            end
        end
        else if (cmd.exec)
        begin
            case (item_reg.func)
                FN_CAPTURE:
                begin
                    if (hit)
                    begin
                        // global registers use bit 15 as set/clear
                        if (g_hit)
                        begin
                            if (word[15])
                            begin
                                global_next[g_idx] = global_reg[g_idx] | word[14:0];
                            end
                            else
                            begin
                                global_next[g_idx] = global_reg[g_idx] & ~word[14:0];
                            end
                            gseen_next[g_idx] = 1'b1;
                        end
                        else if (c_hit)
                        begin
                            chan_next[c_idx]  = word;
                            cseen_next[c_idx] = 1'b1;
                        end
                        latest_next = item_reg.time_stamp;
                        if (full)
                        begin
                            drop_next          = drop_reg + 32'd1;
                            result_next.status = STS_DROPPED;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                            fill_next   = fill_reg + 1'b1;
                            queued_next = queued_reg + 32'd1;
                            result_next.status = STS_QUEUED;
                        end
                    end
                end
                FN_PEEK:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = STS_EMPTY;
                    end
                    else
                    begin
                        result_next.status        = STS_EVENT;
                        result_next.event_address = head_reg.address;
                        result_next.event_value   = head_reg.value;
                        result_next.event_width   = head_reg.width;
                        result_next.event_time    = head_reg.ticks;
                    end
                end
                FN_POP:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = STS_EMPTY;
                    end
                    else
                    begin
                        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                        fill_next   = fill_reg - 1'b1;
                        result_next.status = STS_POPPED;
                    end
                end
                default:
                begin
                    // an enabled snapshot flushes the queue and emits slot zero now
                    if (enable_reg)
                    begin
                        skipped_next = fill_reg;
                        rd_ptr_next  = wr_ptr_reg;
                        fill_next    = '0;
                    end
                end
            endcase
        end

        fill_ext = {9'd0, fill_next};
        skip_ext = {9'd0, skipped_next};
        result_next.pending  = fill_ext[8:0];
        result_next.dropped  = drop_next;
        result_next.captured = queued_next;

        // snapshot entries
        if (cmd.emit || (cmd.exec && stat.snap_go))
        begin
            result_next.status     = STS_SLOT;
            result_next.event_time = latest_reg;
            result_next.pending    = skip_ext[8:0];
            result_next.slot_index = cmd.slot;
            result_next.slot_value = slot_value;
            result_next.slot_seen  = slot_seen;
            result_next.last       = (cmd.slot == SLOT_LAST);
        end
    end

    assign stat.snap_go = (item_reg.func == FN_SNAPSHOT) && enable_reg;

    assign wr_entry.address = item_reg.bus_address;
    assign wr_entry.value   = item_reg.write_value;
    assign wr_entry.width   = item_reg.access_width;
    assign wr_entry.ticks   = item_reg.time_stamp;

    // event queue memory with registered head read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
        head_reg <= mem[rd_ptr_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    // control and shadow registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fill_reg         <= '0;
            skipped_reg      <= '0;
            for (int i = 0; i < GLOBAL_COUNT; i++)
            begin
                global_reg[i] <= '0;
            end
            gseen_reg        <= '0;
            for (int i = 0; i < CHAN_SLOTS; i++)
            begin
                chan_reg[i] <= '0;
            end
            cseen_reg        <= '0;
            latest_reg       <= '0;
            queued_reg       <= '0;
            drop_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg       <= enable_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            fill_reg         <= fill_next;
            skipped_reg      <= skipped_next;
            global_reg       <= global_next;
            gseen_reg        <= gseen_next;
            chan_reg         <= chan_next;
            cseen_reg        <= cseen_next;
            latest_reg       <= latest_next;
            queued_reg       <= queued_next;
            drop_reg         <= drop_next;
            result_valid_reg <= cmd.exec || cmd.emit;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // checks
    `ARSSF_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_FULL, "fill count exceeds queue depth")
    `ARSSF_ASSERT_IMPLY(a_ptr_match, clk, rst_n, (fill_reg == '0) || (fill_reg == FILL_FULL), wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with fill count")
    `ARSSF_ASSERT_NEXT(a_result_strobe, clk, rst_n, cmd.exec || cmd.emit, result_valid_reg, "result strobe missing after execute")

endmodule

`default_nettype wire

// File: hdl/arssf_ctrl.sv
// controller: transaction sequencing and snapshot slot counter
`default_nettype none
`include "audio_register_snoop_shadow_fifo_macros.svh"

module arssf_ctrl
    import arssf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire arssf_stat_t stat,
    output logic             busy,
    output arssf_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SNAP
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] slot_reg,  slot_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.snap_go)
                begin
                    state_next = S_SNAP;
                    slot_next  = 5'd1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SNAP:
            begin
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                    slot_next  = '0;
                end
                else
                begin
                    slot_next = slot_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                slot_next  = '0;
            end
        endcase
    end

    // state and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    // commands to the datapath
    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.emit = (state_reg == S_SNAP);
    assign cmd.slot = slot_reg;

    // checks
    `ARSSF_ASSERT_NEXT(a_load_exec, clk, rst_n, cmd.load, state_reg == S_EXEC, "accepted transaction did not execute")
    `ARSSF_ASSERT_NEXT(a_snap_done, clk, rst_n, (state_reg == S_SNAP) && (slot_reg == SLOT_LAST), state_reg == S_IDLE, "snapshot did not end after last slot")
    `ARSSF_ASSERT_IMPLY(a_slot_idle, clk, rst_n, state_reg != S_SNAP, slot_reg == '0, "slot counter not cleared outside snapshot")

endmodule

`default_nettype wire

// File: hdl/audio_register_snoop_shadow_fifo.sv
// top level of the audio register snoop with shadow and event queue
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; item carries func, bus address, data, width and tick value.
// Results leave on result, marked by result_valid for exactly one cycle;
// the receiver cannot stall, so every strobed cycle is one result.
// Configuration: cfg_we with cfg_wdata writes capture_enable; writing 1
// clears the queue, shadow, latest ticks and both counters.
// Timing: the cycle after acceptance executes the transaction in the
// datapath; the result shows in the next cycle, while busy is already low
// for capture, peek and pop, which pass through the execute state and the
// result register; the head read of the queue memory adds no extra step.
// With capture enabled, a snapshot emits 28 results on consecutive cycles,
// one shadow slot per cycle from the slot counter.
// Reset clears the shadow, pointers, counters and disables capture; queue
// memory contents stay undefined and need no clearing pass.
`default_nettype none

module audio_register_snoop_shadow_fifo
    import arssf_pkg::*;
#(
    parameter int EVENT_DEPTH = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire arssf_in_t  item,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    output logic            result_valid,
    output arssf_out_t      result
);

    arssf_cmd_t  cmd;
    arssf_stat_t stat;

    // sequencing
    arssf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // shadow, queue and result register
    arssf_datapath #(
        .EVENT_DEPTH (EVENT_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

// File: sim/audio_register_snoop_shadow_fifo_tb.sv
// self-checking testbench for the audio register snoop with shadow and event queue
module audio_register_snoop_shadow_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arssf_pkg::*;

    localparam int FIFO_DEPTH  = 256;
    localparam int PAD_CYCLES  = 4;
    localparam int STALL_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    arssf_in_t  item = '0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       result_valid;
    arssf_out_t result;

    // predicted block state
    bit            capture_on = 1'b0;
    arssf_entry_t  event_queue[$];
    logic [14:0]   global_regs [GLOBAL_COUNT];
    logic [3:0]    global_seen = '0;
    logic [15:0]   chan_regs [CHAN_SLOTS];
    logic [5:0]    chan_seen [4];
    logic [63:0]   newest_ticks = '0;
    logic [31:0]   queued_total = '0;
    logic [31:0]   dropped_total = '0;

    // expected results in arrival order
    arssf_out_t    expected_results[$];

    int sender_idle_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int snapshots_taken = 0;
    int stall_cycles = 0;

    audio_register_snoop_shadow_fifo #(.EVENT_DEPTH(FIFO_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // wipe shadow, queue and counters as an enable write does
    task automatic clear_shadow();
        event_queue.delete();
        for (int i = 0; i < GLOBAL_COUNT; i++)
            global_regs[i] = '0;
        for (int i = 0; i < CHAN_SLOTS; i++)
            chan_regs[i] = '0;
        for (int i = 0; i < 4; i++)
            chan_seen[i] = '0;
        global_seen   = '0;
        newest_ticks  = '0;
        queued_total  = '0;
        dropped_total = '0;
    endtask

    function automatic arssf_out_t base_result(input logic [2:0] sts);
        arssf_out_t r;
        r          = '0;
        r.status   = sts;
        r.pending  = 9'(event_queue.size());
        r.dropped  = dropped_total;
        r.captured = queued_total;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic bit audio_hit(input logic [23:0] addr);
        logic [11:0] off;
        off = addr[11:0];
        if (addr[23:12] != AUDIO_PAGE)
            return 1'b0;
        return (off >= CHAN_FIRST && off <= CHAN_LAST_BYTE) ||
               (off >= REG_DMACON && off <= REG_DMACON_HI) ||
               (off >= REG_INTENA && off <= REG_ADKCON_HI);
    endfunction

    // work out the results of one accepted command
    task automatic predict_snoop(input arssf_in_t cmd);
        arssf_out_t   r;
        arssf_entry_t head;
        logic [15:0]  word;
        logic [11:0]  off;
        logic [11:0]  rel;
        int           g;
        int           ch;
        int           idx;
        int           skipped;
        case (cmd.func)
            FN_CAPTURE:
            begin
                if (!capture_on || !audio_hit(cmd.bus_address))
                begin
                    expected_results.push_back(base_result(STS_IGNORED));
                end
                else
                begin
                    // byte writes land on both lanes
                    word = (cmd.access_width == WIDTH_BYTE) ?
                           {2{cmd.write_value[7:0]}} : cmd.write_value;
                    off = {cmd.bus_address[11:1], 1'b0};
                    case (off)
                        REG_DMACON: g = 0;
                        REG_INTENA: g = 1;
                        REG_INTREQ: g = 2;
                        REG_ADKCON: g = 3;
                        default:    g = -1;
                    endcase
                    // set/clear globals, plain word stores for channels
                    if (g >= 0)
                    begin
                        if (word[15])
                            global_regs[g] = global_regs[g] | word[14:0];
                        else
                            global_regs[g] = global_regs[g] & ~word[14:0];
                        global_seen[g] = 1'b1;
                    end
                    else if (off >= CHAN_FIRST && off <= CHAN_LAST_WORD)
                    begin
                        rel = off - CHAN_FIRST;
                        ch  = int'(rel[5:4]);
                        if (rel[3:0] <= CHAN_REG_LAST)
                        begin
                            idx = int'(rel[3:1]);
                            chan_regs[ch * int'(REGS_PER_CHAN) + idx] = word;
                            chan_seen[ch][idx] = 1'b1;
                        end
                    end
                    newest_ticks = cmd.time_stamp;
                    if (event_queue.size() >= FIFO_DEPTH)
                    begin
                        dropped_total++;
                        expected_results.push_back(base_result(STS_DROPPED));
                    end
                    else
                    begin
                        head.address = cmd.bus_address;
                        head.value   = cmd.write_value;
                        head.width   = cmd.access_width;
                        head.ticks   = cmd.time_stamp;
                        event_queue.push_back(head);
                        queued_total++;
                        expected_results.push_back(base_result(STS_QUEUED));
                    end
                end
            end
            FN_PEEK, FN_POP:
            begin
                if (event_queue.size() == 0)
                begin
                    expected_results.push_back(base_result(STS_EMPTY));
                end
                else if (cmd.func == FN_POP)
                begin
                    void'(event_queue.pop_front());
                    expected_results.push_back(base_result(STS_POPPED));
                end
                else
                begin
                    head            = event_queue[0];
                    r               = base_result(STS_EVENT);
                    r.event_address = head.address;
                    r.event_value   = head.value;
                    r.event_width   = head.width;
                    r.event_time    = head.ticks;
                    expected_results.push_back(r);
                end
            end
            default:
            begin
                if (!capture_on)
                begin
                    expected_results.push_back(base_result(STS_IGNORED));
                end
                else
                begin
                    // snapshot skips the queue and dumps every shadow slot
                    snapshots_taken++;
                    skipped = event_queue.size();
                    event_queue.delete();
                    for (int k = 0; k < GLOBAL_COUNT + CHAN_SLOTS; k++)
                    begin
                        r            = base_result(STS_SLOT);
                        r.event_time = newest_ticks;
                        r.pending    = 9'(skipped);
                        r.slot_index = 5'(k);
                        if (k < GLOBAL_COUNT)
                        begin
                            r.slot_value = {1'b0, global_regs[k]};
                            r.slot_seen  = global_seen[k];
                        end
                        else
                        begin
                            ch = (k - GLOBAL_COUNT) / int'(REGS_PER_CHAN);
                            idx = (k - GLOBAL_COUNT) % int'(REGS_PER_CHAN);
                            r.slot_value = chan_regs[k - GLOBAL_COUNT];
                            r.slot_seen  = chan_seen[ch][idx];
                        end
                        r.last = (k == int'(SLOT_LAST));
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    function automatic arssf_in_t make_cmd(input logic [1:0] fn, input logic [23:0] addr,
                                           input logic [15:0] val, input logic [2:0] width,
                                           input logic [63:0] stamp);
        arssf_in_t c;
        c.func         = fn;
        c.bus_address  = addr;
        c.write_value  = val;
        c.access_width = width;
        c.time_stamp   = stamp;
        return c;
    endfunction

    function automatic logic [2:0] rand_width();
        if ($urandom_range(0, 99) < 85)
            return 3'($urandom_range(1, 4));
        return 3'($urandom_range(0, 7));
    endfunction

    // random offset inside one of the audio register windows
    function automatic logic [23:0] rand_hit_address();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return {AUDIO_PAGE, 12'($urandom_range(REG_DMACON, REG_DMACON_HI))};
        if (pick == 1)
            return {AUDIO_PAGE, 12'($urandom_range(REG_INTENA, REG_ADKCON_HI))};
        return {AUDIO_PAGE, 12'($urandom_range(CHAN_FIRST, CHAN_LAST_BYTE))};
    endfunction

    function automatic arssf_in_t rand_capture();
        return make_cmd(FN_CAPTURE, rand_hit_address(), 16'($urandom), rand_width(),
                        {$urandom, $urandom});
    endfunction

    // captures are mostly audio hits, some near misses and some bus noise; the rest peek, pop or snapshot
    function automatic arssf_in_t rand_cmd();
        arssf_in_t c;
        int        roll;
        c = make_cmd(FN_CAPTURE, 24'($urandom), 16'($urandom), rand_width(),
                     {$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                c.bus_address = rand_hit_address();
            else if (roll < 85)
                c.bus_address = {AUDIO_PAGE, 12'($urandom_range(12'h080, 12'h0ff))};
        end
        else if (roll < 65)
            c.func = FN_PEEK;
        else if (roll < 88)
            c.func = FN_POP;
        else
            c.func = FN_SNAPSHOT;
        return c;
    endfunction

    // drive one command, wait for the handshake, then maybe idle
    task automatic send_cmd(input arssf_in_t cmd);
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_snoop(cmd);
        items_sent++;
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop sending and let every expected result come back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (PAD_CYCLES) @(posedge clk);
    endtask

    task automatic write_capture_enable(input bit value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (value)
            clear_shadow();
        capture_on = value;
    endtask

    // everything ignored or empty before capture is enabled
    task automatic disabled_test();
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, REG_DMACON}, 16'h8001, 3'd2, 64'd5));
        send_cmd(make_cmd(FN_SNAPSHOT, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_POP, 24'hffffff, 16'hffff, 3'd7, '1));
    endtask

    // address decode, byte lanes and set/clear globals
    task automatic capture_decode_test();
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, REG_DMACON}, 16'h8005, 3'd2, 64'd0));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, REG_DMACON_HI}, 16'h0081, 3'd1, 64'd1));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, 12'h09b}, 16'hff02, 3'd1, 64'd2));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, REG_INTREQ}, 16'hffff, 3'd4, 64'd3));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, REG_ADKCON}, 16'h7fff, 3'd2, 64'd4));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, REG_ADKCON_HI}, 16'h8000, 3'd0, 64'd5));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, CHAN_FIRST}, 16'h1234, 3'd2, 64'd6));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, CHAN_LAST_WORD}, 16'hbeef, 3'd2, 64'd7));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, CHAN_LAST_BYTE}, 16'h005a, 3'd1, '1));
        // counted but no shadow word behind it
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, 12'h0ac}, 16'h4321, 3'd2, 64'd9));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, 12'h0be}, 16'h0f0f, 3'd4, 64'd10));
        // just outside the windows or the page
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, 12'h095}, 16'hffff, 3'd2, 64'd11));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, 12'h0dc}, 16'hffff, 3'd2, 64'd12));
        send_cmd(make_cmd(FN_CAPTURE, 24'hdfe0a0, 16'hffff, 3'd2, 64'd13));
    endtask

    // head access, snapshot and empty queue
    task automatic fifo_access_test();
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_POP, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_SNAPSHOT, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_POP, '0, '0, '0, '0));
    endtask

    // queue stays readable while disabled, enabling clears it
    task automatic disable_hold_test();
        send_cmd(rand_capture());
        send_cmd(rand_capture());
        write_capture_enable(1'b0);
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_POP, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_CAPTURE, {AUDIO_PAGE, CHAN_FIRST}, 16'h5555, 3'd2, 64'd20));
        send_cmd(make_cmd(FN_SNAPSHOT, '0, '0, '0, '0));
        write_capture_enable(1'b1);
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
    endtask

    // fill the queue past its depth, then drain it by snapshot
    task automatic fill_overflow_test();
        for (int i = 0; i < FIFO_DEPTH + 4; i++)
            send_cmd(rand_capture());
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_POP, '0, '0, '0, '0));
        send_cmd(rand_capture());
        send_cmd(rand_capture());
        send_cmd(make_cmd(FN_SNAPSHOT, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_PEEK, '0, '0, '0, '0));
    endtask

    // random traffic with one full drain halfway
    task automatic random_traffic_test(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_results();
            send_cmd(rand_cmd());
        end
    endtask

    function automatic string fmt_result(input arssf_out_t r);
        return $sformatf({"sts=%0d ev=%h/%h/%0d t=%h pend=%0d drop=%0d cap=%0d ",
                          "slot=%0d/%h/%b last=%b"},
                         r.status, r.event_address, r.event_value, r.event_width,
                         r.event_time, r.pending, r.dropped, r.captured,
                         r.slot_index, r.slot_value, r.slot_seen, r.last);
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        arssf_out_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: %s", fmt_result(result));
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status ||
                    result.event_address !== want.event_address ||
                    result.event_value !== want.event_value ||
                    result.event_width !== want.event_width ||
                    result.event_time !== want.event_time ||
                    result.pending !== want.pending ||
                    result.dropped !== want.dropped ||
                    result.captured !== want.captured ||
                    result.slot_index !== want.slot_index ||
                    result.slot_value !== want.slot_value ||
                    result.slot_seen !== want.slot_seen ||
                    result.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(result));
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clear_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 17;
        disabled_test();
        write_capture_enable(1'b1);
        capture_decode_test();
        fifo_access_test();
        disable_hold_test();
        fill_overflow_test();

        sender_idle_pct = 85;
        write_capture_enable(1'b1);
        random_traffic_test(80);

        sender_idle_pct = 0;
        random_traffic_test(85);

        drain_results();
        $display("sent %0d commands incl. %0d snapshots, checked %0d results",
                 items_sent, snapshots_taken, results_seen);
        $display("queue overflow, enable toggling and all decode windows exercised");
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/arssf_pkg.sv
hdl/arssf_datapath.sv
hdl/arssf_ctrl.sv
hdl/audio_register_snoop_shadow_fifo.sv
sim/audio_register_snoop_shadow_fifo_tb.sv
